[rtl/led_strip_gradient_wipe_fade_unit_macros.svh]
// Assertion macros shared by the gradient wipe fade unit.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LED_STRIP_GRADIENT_WIPE_FADE_UNIT_MACROS_SVH
`define LED_STRIP_GRADIENT_WIPE_FADE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LSGW_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSGW_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lsgw_pkg.sv]
// Shared types and constants of the gradient wipe fade unit.
// Depends on nothing; used by every module of the block.
package lsgw_pkg;

  localparam int IDX_W        = 10;
  localparam int Q16_W        = 17;
  localparam int LEN_W        = 16;
  localparam int COLOR_W      = 24;
  localparam int CHAN_W       = 8;
  localparam int CHANNELS     = 3;
  localparam int STOP_CNT_W   = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int HEAD_SHIFT   = 24;
  localparam int FRONT_STAGES = 5;
  localparam int SHADE_STAGES = 6;

  localparam logic [Q16_W-1:0] Q16_ONE           = 17'h10000;
  localparam logic [LEN_W:0]   LEN_OFFSET        = 17'd256;
  localparam logic [LEN_W-1:0] WIPE_LENGTH_RESET = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STOP_COUNT  = 3'd0,
    CFG_WIPE_LENGTH = 3'd1,
    CFG_COLOR_BASE  = 3'd2
  } cfg_idx_e;

  // Values that ride along a pixel until the color stage needs them.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [Q16_W-1:0] fade;
  } side_t;

  function automatic logic [Q16_W-1:0] sat_q16(input logic [Q16_W-1:0] v);
    return (v > Q16_ONE) ? Q16_ONE : v;
  endfunction

endpackage

[rtl/lsgw_front.sv]
// Wipe head arithmetic: input saturation, head distance and its clamp.
// Depends on lsgw_pkg; feeds the soft-edge divider.
module lsgw_front #(
  parameter int PIXEL_COUNT = 64,
  parameter int DIVISOR_W   = 27
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [lsgw_pkg::IDX_W-1:0]        pixel_index_i,
  input  logic [lsgw_pkg::Q16_W-1:0]        wipe_progress_i,
  input  logic [lsgw_pkg::Q16_W-1:0]        fade_level_i,
  input  logic [lsgw_pkg::LEN_W:0]          len_plus_i,
  input  logic [DIVISOR_W-1:0]              divisor_i,
  output logic                              valid_o,
  output logic [DIVISOR_W+lsgw_pkg::Q16_W-2:0] dividend_o,
  output lsgw_pkg::side_t                   side_o
);

  localparam int NW        = $clog2(PIXEL_COUNT + 1);
  localparam int IDX_W     = lsgw_pkg::IDX_W;
  localparam int Q16_W     = lsgw_pkg::Q16_W;
  localparam int PROD_A_W  = Q16_W + lsgw_pkg::LEN_W + 1;
  localparam int PROD_B_W  = PROD_A_W + NW;
  localparam int DIFF_W    = PROD_B_W + 1;
  localparam int END_W     = DIVISOR_W + Q16_W - 1;

  logic [4:0]          valid_q;
  logic [IDX_W-1:0]    idx1_q, idx2_q, idx3_q, idx4_q;
  logic [Q16_W-1:0]    prog1_q;
  logic [Q16_W-1:0]    fade1_q, fade2_q, fade3_q, fade4_q;
  logic [IDX_W-1:0]    idx1_d;
  logic [PROD_A_W-1:0] pa2_q, pa2_d;
  logic [PROD_B_W-1:0] pb3_q, pb3_d;
  logic [DIFF_W-1:0]   diff4_q, diff4_d;
  logic [END_W-1:0]    dividend5_q, dividend5_d;
  lsgw_pkg::side_t     side5_q;
  logic [END_W-1:0]    den;
  logic                neg, over;

  assign idx1_d = ({1'b0, pixel_index_i} >= (IDX_W+1)'(PIXEL_COUNT)) ?
                  IDX_W'(PIXEL_COUNT - 1) : pixel_index_i;
  assign pa2_d  = PROD_A_W'(prog1_q) * PROD_A_W'(len_plus_i);
  assign pb3_d  = PROD_B_W'(pa2_q) * PROD_B_W'(PIXEL_COUNT);
  // Distance of the wipe head past this pixel, in units of 2^-24 of the strip times N.
  assign diff4_d = DIFF_W'(pb3_q) - DIFF_W'({idx3_q, {lsgw_pkg::HEAD_SHIFT{1'b0}}});

  // Pixels ahead of the head get a zero factor, pixels past the soft edge a full one.
  assign den  = {divisor_i, {(Q16_W-1){1'b0}}};
  assign neg  = diff4_q[DIFF_W-1];
  assign over = diff4_q[DIFF_W-2:0] > (DIFF_W-1)'(den);
  always_comb begin
    priority if (neg) begin
      dividend5_d = '0;
    end else if (over) begin
      dividend5_d = den;
    end else begin
      dividend5_d = diff4_q[END_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q      <= idx1_d;
    prog1_q     <= lsgw_pkg::sat_q16(wipe_progress_i);
    fade1_q     <= lsgw_pkg::sat_q16(fade_level_i);
    idx2_q      <= idx1_q;
    fade2_q     <= fade1_q;
    pa2_q       <= pa2_d;
    idx3_q      <= idx2_q;
    fade3_q     <= fade2_q;
    pb3_q       <= pb3_d;
    idx4_q      <= idx3_q;
    fade4_q     <= fade3_q;
    diff4_q     <= diff4_d;
    dividend5_q <= dividend5_d;
    side5_q     <= '{idx: idx4_q, fade: fade4_q};
  end

  assign valid_o    = valid_q[4];
  assign dividend_o = dividend5_q;
  assign side_o     = side5_q;

endmodule

[rtl/lsgw_div.sv]
// Pipelined restoring divider for the Q1.16 soft-edge factor, one quotient bit per stage.
// Depends on lsgw_pkg and the assertion macro header.
`include "led_strip_gradient_wipe_fade_unit_macros.svh"

module lsgw_div #(
  parameter int DIVISOR_W = 27
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [DIVISOR_W+lsgw_pkg::Q16_W-2:0] dividend_i,
  input  lsgw_pkg::side_t                      side_i,
  input  logic [DIVISOR_W-1:0]                 divisor_i,
  output logic                                 valid_o,
  output logic [lsgw_pkg::Q16_W-1:0]           quot_o,
  output lsgw_pkg::side_t                      side_o
);

  localparam int QUOT_W = lsgw_pkg::Q16_W;
  localparam int REM_W  = DIVISOR_W + QUOT_W;

  logic [QUOT_W-1:0] valid_q;
  logic [REM_W-1:0]  rem_q  [QUOT_W];
  logic [QUOT_W-1:0] quo_q  [QUOT_W];
  lsgw_pkg::side_t   side_q [QUOT_W];

  for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
    localparam int Bit = QUOT_W - 1 - s;

    logic              v_in;
    logic [REM_W-1:0]  r_in;
    logic [QUOT_W-1:0] qo_in;
    lsgw_pkg::side_t   sd_in;
    logic [REM_W:0]    trial;
    logic [REM_W-1:0]  rem_d;
    logic [QUOT_W-1:0] quo_d;

    if (s == 0) begin : g_first
      assign v_in  = valid_i;
      assign r_in  = REM_W'(dividend_i);
      assign qo_in = '0;
      assign sd_in = side_i;
    end else begin : g_next
      assign v_in  = valid_q[s-1];
      assign r_in  = rem_q[s-1];
      assign qo_in = quo_q[s-1];
      assign sd_in = side_q[s-1];
    end

    // The remainder stays below divisor << (Bit + 1), so one trial subtract settles the bit.
    assign trial = {1'b0, r_in} - ((REM_W+1)'(divisor_i) << Bit);
    assign rem_d = trial[REM_W] ? r_in : trial[REM_W-1:0];
    assign quo_d = trial[REM_W] ? qo_in : (qo_in | (QUOT_W'(1) << Bit));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      quo_q[s]  <= quo_d;
      side_q[s] <= sd_in;
    end
  end

  assign valid_o = valid_q[QUOT_W-1];
  assign quot_o  = quo_q[QUOT_W-1];
  assign side_o  = side_q[QUOT_W-1];

  `LSGW_ASSERT_IMP(a_quot_at_most_one, clk_i, rst_ni, valid_o,
    !(quot_o[QUOT_W-1] && (quot_o[QUOT_W-2:0] != '0)), "soft-edge factor above 1.0")
  `LSGW_ASSERT_IMP(a_rem_below_divisor, clk_i, rst_ni, valid_o,
    rem_q[QUOT_W-1] < REM_W'(divisor_i), "divider remainder not below divisor")
  `LSGW_ASSERT_NXT(a_div_latency, clk_i, rst_ni, $past(valid_i, QUOT_W-1),
    valid_o, "divider dropped a beat")

endmodule

[rtl/lsgw_shade.sv]
// Gradient lookup between color stops, exact divide by the pixel count,
// and the final wipe and fade scaling. Depends on lsgw_pkg.
module lsgw_shade #(
  parameter int PIXEL_COUNT = 64,
  parameter int MAX_STOPS   = 6
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  valid_i,
  input  logic [lsgw_pkg::Q16_W-1:0]                            quot_i,
  input  lsgw_pkg::side_t                                       side_i,
  input  logic [$clog2(MAX_STOPS)-1:0]                          span_i,
  input  logic [MAX_STOPS-1:0][lsgw_pkg::COLOR_W-1:0]           colors_i,
  output logic                                                  valid_o,
  output logic [lsgw_pkg::CHAN_W-1:0]                           red_o,
  output logic [lsgw_pkg::CHAN_W-1:0]                           green_o,
  output logic [lsgw_pkg::CHAN_W-1:0]                           blue_o
);

  localparam int CHAN_W    = lsgw_pkg::CHAN_W;
  localparam int CHANNELS  = lsgw_pkg::CHANNELS;
  localparam int COLOR_W   = lsgw_pkg::COLOR_W;
  localparam int Q16_W     = lsgw_pkg::Q16_W;
  localparam int NW        = $clog2(PIXEL_COUNT + 1);
  localparam int SEG_W     = $clog2(MAX_STOPS);
  localparam int T_W       = lsgw_pkg::IDX_W + SEG_W;
  localparam int X_W       = CHAN_W + NW;
  // floor(x / N) as (x * RECIP) >> DIV_SHIFT is exact for every x below 256 * N.
  localparam int DIV_SHIFT = CHAN_W + 2 * $clog2(PIXEL_COUNT);
  localparam int RECIP     = (2 ** DIV_SHIFT + PIXEL_COUNT - 1) / PIXEL_COUNT;
  localparam int RECIP_W   = DIV_SHIFT - $clog2(PIXEL_COUNT) + 2;
  localparam int PROD_W    = X_W + RECIP_W;
  localparam int QF_W      = 2 * Q16_W - 1;
  localparam int OUT_W     = CHAN_W + QF_W;
  localparam int STAGES    = lsgw_pkg::SHADE_STAGES;

  logic [STAGES-1:0]                    valid_q;
  logic [T_W-1:0]                       t1_q, t1_d;
  logic [QF_W-1:0]                      qf1_q, qf2_q, qf3_q, qf4_q, qf5_q, qf1_d;
  logic [SEG_W-1:0]                     seg2_q, seg2_d;
  logic [NW-1:0]                        rem2_q, rem2_d;
  logic [T_W-1:0]                       off;
  logic [COLOR_W-1:0]                   col_a, col_b;
  logic [CHANNELS-1:0][X_W-1:0]         pa3_q, pb3_q, pa3_d, pb3_d;
  logic [CHANNELS-1:0][X_W-1:0]         x4_q, x4_d;
  logic [CHANNELS-1:0][PROD_W-1:0]      prod5_q, prod5_d;
  logic [CHANNELS-1:0][OUT_W-1:0]       scaled;
  logic [CHANNELS-1:0][CHAN_W-1:0]      out6_q, out6_d;

  assign t1_d  = T_W'(side_i.idx) * T_W'(span_i);
  assign qf1_d = QF_W'(quot_i) * QF_W'(side_i.fade);

  // Segment number by compare against the fixed segment boundaries.
  always_comb begin
    seg2_d = '0;
    off    = '0;
    for (int k = 1; k < MAX_STOPS - 1; k++) begin
      if (t1_q >= T_W'(k * PIXEL_COUNT)) begin
        seg2_d = SEG_W'(k);
        off    = T_W'(k * PIXEL_COUNT);
      end
    end
    rem2_d = NW'(t1_q - off);
  end

  always_comb begin
    col_a = '0;
    col_b = '0;
    for (int k = 0; k < MAX_STOPS - 1; k++) begin
      if (seg2_q == SEG_W'(k)) begin
        col_a = colors_i[k];
        col_b = colors_i[k+1];
      end
    end
    for (int c = 0; c < CHANNELS; c++) begin
      pa3_d[c] = X_W'(col_a[COLOR_W-1-CHAN_W*c -: CHAN_W]) *
                 X_W'(NW'(PIXEL_COUNT) - rem2_q);
      pb3_d[c] = X_W'(col_b[COLOR_W-1-CHAN_W*c -: CHAN_W]) * X_W'(rem2_q);
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      x4_d[c]    = pa3_q[c] + pb3_q[c];
      prod5_d[c] = PROD_W'(x4_q[c]) * PROD_W'(RECIP);
      scaled[c]  = OUT_W'(prod5_q[c][DIV_SHIFT +: CHAN_W]) * OUT_W'(qf5_q);
      out6_d[c]  = scaled[c][2*(Q16_W-1) +: CHAN_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q    <= t1_d;
    qf1_q   <= qf1_d;
    seg2_q  <= seg2_d;
    rem2_q  <= rem2_d;
    qf2_q   <= qf1_q;
    pa3_q   <= pa3_d;
    pb3_q   <= pb3_d;
    qf3_q   <= qf2_q;
    x4_q    <= x4_d;
    qf4_q   <= qf3_q;
    prod5_q <= prod5_d;
    qf5_q   <= qf4_q;
    out6_q  <= out6_d;
  end

  assign valid_o = valid_q[STAGES-1];
  assign red_o   = out6_q[0];
  assign green_o = out6_q[1];
  assign blue_o  = out6_q[2];

endmodule

[rtl/led_strip_gradient_wipe_fade_unit.sv]
// Top level of the gradient wipe fade unit: configuration registers and the pixel pipeline.
// Depends on lsgw_pkg, lsgw_front, lsgw_div, lsgw_shade and the assertion macro header.
//
// Usage: a pixel beat is taken at each clock edge where start is high and busy is low.
// busy never rises, so a new pixel may be offered in every cycle with no gaps.
// Each pixel carries its index on the strip, the wipe progress and the fade level
// (Q1.16, 65536 meaning 1.0); values above 1.0 are clipped, indexes past the strip
// end are clipped to the last pixel.
// Each pixel passes in turn through 5 stages of wipe head arithmetic, 17 stages
// of the restoring divider that forms the soft-edge factor (one quotient bit each),
// and 6 stages of gradient lookup and scaling. Throughput is one pixel per cycle.
// The result appears on red_o, green_o and blue_o for exactly one cycle with
// result_valid_o high; the receiver cannot hold it off and results leave in order.
// Registers are written through the cfg channel (cfg_ready_o is always high) and take
// effect on the next cycle; write them only while no pixel is in flight.
// Reset empties the pipeline and loads two stops, a wipe length of 1.0 and black stops.
`include "led_strip_gradient_wipe_fade_unit_macros.svh"

module led_strip_gradient_wipe_fade_unit #(
  parameter int PIXEL_COUNT = 64,
  parameter int MAX_STOPS   = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [lsgw_pkg::IDX_W-1:0]          pixel_index_i,
  input  logic [lsgw_pkg::Q16_W-1:0]          wipe_progress_i,
  input  logic [lsgw_pkg::Q16_W-1:0]          fade_level_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lsgw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lsgw_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                result_valid_o,
  output logic [lsgw_pkg::CHAN_W-1:0]         red_o,
  output logic [lsgw_pkg::CHAN_W-1:0]         green_o,
  output logic [lsgw_pkg::CHAN_W-1:0]         blue_o
);

  localparam int NW        = $clog2(PIXEL_COUNT + 1);
  localparam int SEG_W     = $clog2(MAX_STOPS);
  localparam int LEN_W     = lsgw_pkg::LEN_W;
  localparam int COLOR_W   = lsgw_pkg::COLOR_W;
  localparam int CFG_IDX_W = lsgw_pkg::CFG_IDX_W;
  localparam int CNT_W     = lsgw_pkg::STOP_CNT_W;
  localparam int DIV_W     = LEN_W + NW;
  localparam int END_W     = DIV_W + lsgw_pkg::Q16_W - 1;
  localparam int LATENCY   = lsgw_pkg::FRONT_STAGES + lsgw_pkg::Q16_W +
                             lsgw_pkg::SHADE_STAGES;

  localparam logic [LEN_W:0]   LEN_PLUS_RST =
    {1'b0, lsgw_pkg::WIPE_LENGTH_RESET} + lsgw_pkg::LEN_OFFSET;
  localparam logic [DIV_W-1:0] DIVISOR_RST  =
    DIV_W'(lsgw_pkg::WIPE_LENGTH_RESET) * DIV_W'(PIXEL_COUNT);

  // Stop count is kept as the number of segments, wipe length as length + 1.0
  // and as length * N, the divisor of the soft-edge factor.
  logic [SEG_W-1:0]                  span_q, span_d;
  logic [LEN_W:0]                    len_plus_q, len_plus_d;
  logic [DIV_W-1:0]                  divisor_q, divisor_d;
  logic [MAX_STOPS-1:0][COLOR_W-1:0] colors_q, colors_d;

  logic                   cfg_we;
  logic [CNT_W-1:0]       stop_cnt;
  logic [LEN_W-1:0]       len_raw, len_eff;
  logic [CFG_IDX_W-1:0]   color_slot;
  logic                   accept;

  logic                   front_valid;
  logic [END_W-1:0]       front_dividend;
  lsgw_pkg::side_t        front_side;
  logic                   div_valid;
  logic [lsgw_pkg::Q16_W-1:0] div_quot;
  lsgw_pkg::side_t        div_side;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  assign stop_cnt   = cfg_data_i[CNT_W-1:0];
  assign len_raw    = cfg_data_i[LEN_W-1:0];
  assign len_eff    = (len_raw == '0) ? LEN_W'(1) : len_raw;
  assign color_slot = cfg_index_i - lsgw_pkg::CFG_COLOR_BASE;

  always_comb begin
    span_d     = span_q;
    len_plus_d = len_plus_q;
    divisor_d  = divisor_q;
    colors_d   = colors_q;
    if (cfg_we) begin
      if (cfg_index_i == lsgw_pkg::CFG_STOP_COUNT) begin
        priority if (stop_cnt == '0) begin
          span_d = '0;
        end else if (stop_cnt > CNT_W'(MAX_STOPS)) begin
          span_d = SEG_W'(MAX_STOPS - 1);
        end else begin
          span_d = SEG_W'(stop_cnt - CNT_W'(1));
        end
      end else if (cfg_index_i == lsgw_pkg::CFG_WIPE_LENGTH) begin
        len_plus_d = {1'b0, len_eff} + lsgw_pkg::LEN_OFFSET;
        divisor_d  = DIV_W'(len_eff) * DIV_W'(PIXEL_COUNT);
      end else begin
        // Stops past MAX_STOPS are never read, so writes to them are dropped.
        for (int k = 0; k < MAX_STOPS; k++) begin
          if (color_slot == CFG_IDX_W'(k)) begin
            colors_d[k] = cfg_data_i[COLOR_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q     <= SEG_W'(1);
      len_plus_q <= LEN_PLUS_RST;
      divisor_q  <= DIVISOR_RST;
      colors_q   <= '0;
    end else begin
      span_q     <= span_d;
      len_plus_q <= len_plus_d;
      divisor_q  <= divisor_d;
      colors_q   <= colors_d;
    end
  end

  lsgw_front #(
    .PIXEL_COUNT (PIXEL_COUNT),
    .DIVISOR_W   (DIV_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (accept),
    .pixel_index_i   (pixel_index_i),
    .wipe_progress_i (wipe_progress_i),
    .fade_level_i    (fade_level_i),
    .len_plus_i      (len_plus_q),
    .divisor_i       (divisor_q),
    .valid_o         (front_valid),
    .dividend_o      (front_dividend),
    .side_o          (front_side)
  );

  lsgw_div #(
    .DIVISOR_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (front_valid),
    .dividend_i (front_dividend),
    .side_i     (front_side),
    .divisor_i  (divisor_q),
    .valid_o    (div_valid),
    .quot_o     (div_quot),
    .side_o     (div_side)
  );

  lsgw_shade #(
    .PIXEL_COUNT (PIXEL_COUNT),
    .MAX_STOPS   (MAX_STOPS)
  ) u_shade (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (div_valid),
    .quot_i   (div_quot),
    .side_i   (div_side),
    .span_i   (span_q),
    .colors_i (colors_q),
    .valid_o  (result_valid_o),
    .red_o    (red_o),
    .green_o  (green_o),
    .blue_o   (blue_o)
  );

  `LSGW_ASSERT_IMP(a_result_latency, clk_i, rst_ni, $past(accept, LATENCY),
    result_valid_o, "accepted pixel beat did not come out")
  `LSGW_ASSERT_IMP(a_fade_off_black, clk_i, rst_ni,
    result_valid_o && $past(accept && (fade_level_i == '0), LATENCY),
    (red_o == '0) && (green_o == '0) && (blue_o == '0), "zero fade gave a lit pixel")
  `LSGW_ASSERT_IMP(a_no_progress_black, clk_i, rst_ni,
    result_valid_o && $past(accept && (wipe_progress_i == '0), LATENCY),
    (red_o == '0) && (green_o == '0) && (blue_o == '0), "unwiped pixel is lit")

endmodule
